FILE: sv/pic_pkg.sv
`timescale 1ns / 1ps

package pic_pkg;

	// Gains are Q8.8; the integral increment is scaled by 1e9 ns per second and the gain fraction.
	localparam int GAIN_FRAC_BITS = 8;

	// Bit-serial loop lengths: one step per dt bit, then one step per bit of the reciprocal.
	localparam int DT_W   = 32;
	localparam int PROD_W = 80;
	localparam int QUO_W  = 41;

	// The divisor 1e9 * 2^GAIN_FRAC_BITS is 2^(GAIN_FRAC_BITS + 9) * 5^9. The product is shifted
	// right by the power of two and multiplied by floor(2^61 / 5^9). That estimate is either the
	// quotient or one below it, and the low bits of the remainder settle which.
	localparam int RCP_SHIFT = GAIN_FRAC_BITS + 9;
	localparam int NUM_W     = PROD_W - 1 - RCP_SHIFT;
	localparam int RCP_W     = 41;
	localparam int RCP_FRAC  = 61;
	localparam int RACC_W    = NUM_W + 1 + RCP_W;
	localparam logic [RCP_W-1:0] RCP_M   = 41'd1180591620717;
	localparam logic [20:0]      DIV_ODD = 21'd1953125;

	localparam int PC_W  = 4;
	localparam int CNT_W = 7;
	localparam int OP_W  = 4;
	localparam int CND_W = 3;

	localparam logic [CNT_W-1:0] MUL_CNT = CNT_W'(DT_W - 1);
	localparam logic [CNT_W-1:0] RCP_CNT = CNT_W'(RCP_W - 1);

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_KP      = 2'd0;
	localparam logic [1:0] REG_KI      = 2'd1;
	localparam logic [1:0] REG_INT_LOW = 2'd2;
	localparam logic [1:0] REG_INT_HIGH = 2'd3;

	// Datapath operations
	localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
	localparam logic [OP_W-1:0] OP_LATCH   = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL_KI  = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL_KP  = 4'd3;
	localparam logic [OP_W-1:0] OP_SHADD   = 4'd4;
	localparam logic [OP_W-1:0] OP_RCPSTEP = 4'd5;
	localparam logic [OP_W-1:0] OP_FIX     = 4'd6;
	localparam logic [OP_W-1:0] OP_SUM     = 4'd7;
	localparam logic [OP_W-1:0] OP_CLAMP   = 4'd8;
	localparam logic [OP_W-1:0] OP_OUT     = 4'd9;

	// Jump conditions
	localparam logic [CND_W-1:0] COND_NEXT     = 3'd0;
	localparam logic [CND_W-1:0] COND_JUMP     = 3'd1;
	localparam logic [CND_W-1:0] COND_NO_IN    = 3'd2;
	localparam logic [CND_W-1:0] COND_LOOP     = 3'd3;
	localparam logic [CND_W-1:0] COND_OUT_BUSY = 3'd4;

	// Program addresses
	localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] PC_MULKI = 4'd1;
	localparam logic [PC_W-1:0] PC_MULKP = 4'd2;
	localparam logic [PC_W-1:0] PC_SHADD = 4'd3;
	localparam logic [PC_W-1:0] PC_RCP   = 4'd4;
	localparam logic [PC_W-1:0] PC_FIX   = 4'd5;
	localparam logic [PC_W-1:0] PC_SUM   = 4'd6;
	localparam logic [PC_W-1:0] PC_CLAMP = 4'd7;
	localparam logic [PC_W-1:0] PC_OUT   = 4'd8;
	localparam logic [PC_W-1:0] PC_RET   = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CND_W-1:0] cond;
		logic [PC_W-1:0]  target;
		logic             load_cnt;
		logic [CNT_W-1:0] cnt_val;
	} ucode_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dp_ctl_t;

	typedef struct packed {
		logic [15:0] kp_gain;
		logic [15:0] ki_gain;
		logic [31:0] integral_low;
		logic [31:0] integral_high;
	} cfg_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_JUMP, target: PC_IDLE, load_cnt: 1'b0, cnt_val: '0};
		case (pc)
			PC_IDLE:  w = '{OP_LATCH,   COND_NO_IN,    PC_IDLE,  1'b0, '0};
			PC_MULKI: w = '{OP_MUL_KI,  COND_NEXT,     PC_IDLE,  1'b0, '0};
			PC_MULKP: w = '{OP_MUL_KP,  COND_NEXT,     PC_IDLE,  1'b1, MUL_CNT};
			PC_SHADD: w = '{OP_SHADD,   COND_LOOP,     PC_SHADD, 1'b1, RCP_CNT};
			PC_RCP:   w = '{OP_RCPSTEP, COND_LOOP,     PC_RCP,   1'b0, '0};
			PC_FIX:   w = '{OP_FIX,     COND_NEXT,     PC_IDLE,  1'b0, '0};
			PC_SUM:   w = '{OP_SUM,     COND_NEXT,     PC_IDLE,  1'b0, '0};
			PC_CLAMP: w = '{OP_CLAMP,   COND_NEXT,     PC_IDLE,  1'b0, '0};
			PC_OUT:   w = '{OP_OUT,     COND_OUT_BUSY, PC_OUT,   1'b0, '0};
			PC_RET:   w = '{OP_NOP,     COND_JUMP,     PC_IDLE,  1'b0, '0};
			default:  w = '{OP_NOP,     COND_JUMP,     PC_IDLE,  1'b0, '0};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/pi_controller_clamped_integral.sv
`timescale 1ns / 1ps

// Parallel PI controller on Q16.16 data with Q8.8 gains and a clamped integral. Each input
// transaction is one sample; it yields exactly one output transaction carrying the effort and
// the integral after the step. From acceptance to the result being offered, a small microcoded
// sequencer runs the datapath through a 32-step shift-add multiply of the error-gain product by
// the time step, then divides by 1e9 * 256 with a 41-step shift-add multiply by a fixed
// reciprocal and a one-step remainder correction. Only one sample is in flight; the next is
// accepted after the result has been written to the output register and the sequencer has gone
// through its return step back to idle. The output register holds a result while the output is
// stalled, and a stalled output holds the next sample at its output step. Configuration writes
// must be made while no sample is being processed.
module pi_controller_clamped_integral import pic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] setpoint,
	input  logic signed [31:0] measurement,
	input  logic [63:0]        timestamp_ns,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] effort,
	output logic signed [31:0] integral_now
);

	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	cfg_t             cfg_q;

	ucode_t           uw;
	logic             taken;
	logic             gated;
	dp_ctl_t          dp_ctl;

	always_comb begin
		uw = ucode_rom(pc_q);
		case (uw.cond)
			COND_NEXT:     taken = 1'b0;
			COND_JUMP:     taken = 1'b1;
			COND_NO_IN:    taken = !in_valid;
			COND_LOOP:     taken = (cnt_q != '0);
			COND_OUT_BUSY: taken = out_valid_q && out_stall;
			default:       taken = 1'b1;
		endcase
		// A wait step only does its work in the cycle it leaves the wait
		gated     = taken && (uw.cond == COND_NO_IN || uw.cond == COND_OUT_BUSY);
		dp_ctl.op = gated ? OP_NOP : uw.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q <= taken ? uw.target : (pc_q + PC_W'(1));
			if (uw.cond == COND_LOOP && taken) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else if (uw.load_cnt) begin
				cnt_q <= uw.cnt_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_ctl.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP:       cfg_q.kp_gain       <= cfg_wdata[15:0];
				REG_KI:       cfg_q.ki_gain       <= cfg_wdata[15:0];
				REG_INT_LOW:  cfg_q.integral_low  <= cfg_wdata;
				REG_INT_HIGH: cfg_q.integral_high <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = (pc_q != PC_IDLE);
	assign out_valid = out_valid_q;

	pic_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (dp_ctl),
		.cfg          (cfg_q),
		.setpoint     (setpoint),
		.measurement  (measurement),
		.timestamp_ns (timestamp_ns),
		.effort       (effort),
		.integral_now (integral_now)
	);

	// A result only appears after the output step of the program
	a_out_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q) == PC_OUT)
		else $error("output became valid outside the output step");

	// Leaving the multiply loop must arm the reciprocal loop with its full count
	a_rcp_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_SHADD && cnt_q == '0) |=> (pc_q == PC_RCP && cnt_q == RCP_CNT))
		else $error("reciprocal loop not armed after multiply loop");

	// With ordered limits a fresh integral lies inside them
	a_integral_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && $signed(cfg_q.integral_low) <= $signed(cfg_q.integral_high))
		|-> ($signed(integral_now) >= $signed(cfg_q.integral_low)
			&& $signed(integral_now) <= $signed(cfg_q.integral_high)))
		else $error("integral outside its limits");

endmodule

FILE: sv/pic_dpath.sv
`timescale 1ns / 1ps

module pic_dpath import pic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctl_t            ctl,
	input  cfg_t               cfg,
	input  logic signed [31:0] setpoint,
	input  logic signed [31:0] measurement,
	input  logic [63:0]        timestamp_ns,
	output logic signed [31:0] effort,
	output logic signed [31:0] integral_now
);

	logic signed [32:0] err_diff;
	logic [31:0]        err_sat;
	logic [64:0]        ts_diff;
	logic [31:0]        dt_new;

	logic [31:0]        err_q;
	logic [31:0]        dt_q;
	logic [63:0]        last_q;
	logic               stamp_valid_q;

	logic [15:0]        gain;
	logic [31:0]        err_mag;
	logic [15:0]        gain_mag;
	logic [47:0]        mul_p;
	logic               prod_neg;
	logic [39:0]        prop_mag;

	logic [46:0]        pmag_q;
	logic               eki_neg_q;
	logic [40:0]        prop_q;

	logic [PROD_W-1:0]  r_q;
	logic [47:0]        hi_add;

	logic [RACC_W-1:0]  racc_q;
	logic [NUM_W:0]     racc_add;
	logic [NUM_W-1:0]   num;
	logic [QUO_W-1:0]   quo_est;
	logic [31:0]        fix_prod;
	logic [31:0]        fix_rem;
	logic [QUO_W-1:0]   quo_q;

	logic [42:0]        inc;
	logic [43:0]        sum_d;
	logic [43:0]        sum_q;
	logic [43:0]        lo_ext;
	logic [43:0]        hi_ext;
	logic [43:0]        clamp_v;

	logic [31:0]        acc_q;
	logic [41:0]        eff_sum;
	logic [31:0]        eff_sat;
	logic [31:0]        effort_q;
	logic [31:0]        integ_q;

	// Error, saturated to the 32-bit data range
	always_comb begin
		err_diff = {setpoint[31], setpoint} - {measurement[31], measurement};
		if (err_diff[32] != err_diff[31]) begin
			err_sat = err_diff[32] ? S32_MIN : S32_MAX;
		end else begin
			err_sat = err_diff[31:0];
		end
	end

	// Time step: zero on the first sample or when time runs backwards, capped at 32 bits
	always_comb begin
		ts_diff = {1'b0, timestamp_ns} - {1'b0, last_q};
		if (!stamp_valid_q || ts_diff[64]) begin
			dt_new = '0;
		end else if (|ts_diff[63:32]) begin
			dt_new = '1;
		end else begin
			dt_new = ts_diff[31:0];
		end
	end

	// One shared magnitude multiplier serves both gains
	always_comb begin
		gain     = (ctl.op == OP_MUL_KI) ? cfg.ki_gain : cfg.kp_gain;
		err_mag  = err_q[31] ? (~err_q + 32'd1) : err_q;
		gain_mag = gain[15] ? (~gain + 16'd1) : gain;
		mul_p    = 48'(err_mag) * 48'(gain_mag);
		prod_neg = err_q[31] ^ gain[15];
		prop_mag = mul_p[47:GAIN_FRAC_BITS];
	end

	always_comb begin
		hi_add = r_q[0] ? (r_q[79:32] + {1'b0, pmag_q}) : r_q[79:32];
	end

	// The reciprocal product runs as a shift-add over the constant's bits; the remainder of the
	// estimate is small, so its low 32 bits are enough to tell whether one more is due.
	always_comb begin
		num      = r_q[PROD_W-2:RCP_SHIFT];
		racc_add = racc_q[0] ? (racc_q[RACC_W-1:RCP_W] + {1'b0, num})
			: racc_q[RACC_W-1:RCP_W];
		quo_est  = racc_q[RCP_FRAC+QUO_W-1:RCP_FRAC];
		fix_prod = quo_est[31:0] * 32'(DIV_ODD);
		fix_rem  = num[31:0] - fix_prod;
	end

	// Integral update and clamp; the upper limit is applied last so it wins on inverted limits
	always_comb begin
		inc    = eki_neg_q ? (43'd0 - {2'b00, quo_q}) : {2'b00, quo_q};
		sum_d  = {{12{acc_q[31]}}, acc_q} + {inc[42], inc};
		lo_ext = {{12{cfg.integral_low[31]}}, cfg.integral_low};
		hi_ext = {{12{cfg.integral_high[31]}}, cfg.integral_high};
		clamp_v = sum_q;
		if ($signed(clamp_v) < $signed(lo_ext)) begin
			clamp_v = lo_ext;
		end
		if ($signed(clamp_v) > $signed(hi_ext)) begin
			clamp_v = hi_ext;
		end
	end

	always_comb begin
		eff_sum = {prop_q[40], prop_q} + {{10{acc_q[31]}}, acc_q};
		if (eff_sum[41:31] == {11{eff_sum[41]}}) begin
			eff_sat = eff_sum[31:0];
		end else begin
			eff_sat = eff_sum[41] ? S32_MIN : S32_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			last_q        <= '0;
			stamp_valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_LATCH: begin
					last_q        <= timestamp_ns;
					stamp_valid_q <= 1'b1;
				end
				OP_CLAMP: begin
					acc_q <= clamp_v[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				err_q <= err_sat;
				dt_q  <= dt_new;
			end
			OP_MUL_KI: begin
				pmag_q    <= mul_p[46:0];
				eki_neg_q <= prod_neg;
				r_q       <= {48'd0, dt_q};
				racc_q    <= RACC_W'(RCP_M);
			end
			OP_MUL_KP: begin
				prop_q <= prod_neg ? (41'd0 - {1'b0, prop_mag}) : {1'b0, prop_mag};
			end
			OP_SHADD: begin
				r_q <= {1'b0, hi_add, r_q[31:1]};
			end
			OP_RCPSTEP: begin
				racc_q <= {1'b0, racc_add, racc_q[RCP_W-1:1]};
			end
			OP_FIX: begin
				quo_q <= (fix_rem >= 32'(DIV_ODD)) ? (quo_est + QUO_W'(1)) : quo_est;
			end
			OP_SUM: begin
				sum_q <= sum_d;
			end
			OP_OUT: begin
				effort_q <= eff_sat;
				integ_q  <= acc_q;
			end
			default: begin
			end
		endcase
	end

	assign effort       = effort_q;
	assign integral_now = integ_q;

endmodule
